// ===== rtl/sha256_pkg.sv =====
// Package with SHA-256 constants, shared types and round functions.
`timescale 1ns / 1ps
package sha256_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrW  = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } cmd_t;

    localparam logic [31:0] InitialH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ===== rtl/sha256_message_hasher.sv =====
// Top level of the SHA-256 message hasher: input queue and hashing engine.
`timescale 1ns / 1ps
// Message bytes arrive one per beat and are taken in one per cycle while the engine is idle; every
// 64th byte starts a compression of 64 rounds, one round per cycle, followed by a final addition
// step into the chaining value. A four-beat queue in front lets the source send up to four beats
// while a block compresses. The end-of-message beat adds padding at one byte per cycle, one or two
// further compressions, then eight digest beats, H0 first, with last_word on the eighth; the block
// then starts a fresh message.
module sha256_message_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_present,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);
    logic             q_valid;
    logic             q_ready;
    sha256_pkg::cmd_t q_cmd;

    sha256_queue u_queue (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_byte_present   (s_byte_present),
        .s_end_of_message (s_end_of_message),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_cmd            (q_cmd)
    );

    sha256_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_cmd         (q_cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );
endmodule

// ===== rtl/sha256_queue.sv =====
// Short queue of input beats between the front end and the hashing engine.
`timescale 1ns / 1ps
module sha256_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic                s_byte_present,
    input  logic                s_end_of_message,
    output logic                q_valid,
    input  logic                q_ready,
    output sha256_pkg::cmd_t    q_cmd
);
    sha256_pkg::cmd_t                   mem_reg [sha256_pkg::QueueDepth];
    logic [sha256_pkg::QueuePtrW-1:0]   wr_ptr_reg;
    logic [sha256_pkg::QueuePtrW-1:0]   rd_ptr_reg;
    logic [sha256_pkg::QueuePtrW:0]     count_reg;
    logic                               push;
    logic                               pop;

    assign s_ready = (count_reg != (sha256_pkg::QueuePtrW+1)'(sha256_pkg::QueueDepth));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= '{s_data_byte, s_byte_present, s_end_of_message};
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + (sha256_pkg::QueuePtrW)'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + (sha256_pkg::QueuePtrW)'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (sha256_pkg::QueuePtrW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (sha256_pkg::QueuePtrW+1)'(1);
            end
        end
    end
endmodule

// ===== rtl/sha256_engine.sv =====
// Hashing engine: block assembly, padding, one round per cycle and digest output.
`timescale 1ns / 1ps
module sha256_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  sha256_pkg::cmd_t    q_cmd,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [31:0]         m_digest_word,
    output logic [2:0]          m_word_index,
    output logic                m_last_word
);
    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StRound = 3'd1;
    localparam logic [2:0] StPad   = 3'd2;
    localparam logic [2:0] StLen   = 3'd3;
    localparam logic [2:0] StOut   = 3'd4;
    localparam logic [2:0] StAdd   = 3'd5;

    logic [2:0]  state_reg;
    logic [2:0]  ret_reg;
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [63:0] bit_count_reg;
    logic [5:0]  pos_reg;
    logic [5:0]  round_reg;
    logic [2:0]  len_reg;
    logic        fin_reg;
    logic [2:0]  out_idx_reg;

    logic [7:0]  put_val;
    logic        put_en;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_cur;
    logic [63:0] len_word;

    assign q_ready       = (state_reg == StIdle);
    assign m_valid       = (state_reg == StOut);
    assign m_digest_word = h_reg[out_idx_reg];
    assign m_word_index  = out_idx_reg;
    assign m_last_word   = (out_idx_reg == 3'd7);

    assign w_new = w_reg[0] + sha256_pkg::sig0(w_reg[1]) + w_reg[9] + sha256_pkg::sig1(w_reg[14]);
    assign w_cur = w_reg[0];
    assign t1 = v_reg[7] + sha256_pkg::bsig1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + sha256_pkg::RoundK[round_reg] + w_cur;
    assign t2 = sha256_pkg::bsig0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign len_word = bit_count_reg << {len_reg, 3'b000};

    always_comb begin
        put_en  = 1'b0;
        put_val = 8'h00;
        case (state_reg)
            StIdle: begin
                put_en  = q_valid && q_cmd.byte_present;
                put_val = q_cmd.data_byte;
            end
            StPad: begin
                put_en  = 1'b1;
                put_val = fin_reg ? 8'h00 : 8'h80;
            end
            StLen: begin
                put_en  = 1'b1;
                put_val = len_word[63:56];
            end
            default: begin
                put_en  = 1'b0;
                put_val = 8'h00;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (put_en) begin
            w_reg[pos_reg[5:2]] <= (pos_reg[1:0] == 2'd0) ? {put_val, 24'h0}
                : (w_reg[pos_reg[5:2]] | ({24'h0, put_val} << {~pos_reg[1:0], 3'b000}));
        end
        if (state_reg == StRound) begin
            for (int i = 0; i < 15; i++) begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
            for (int i = 1; i < 8; i++) begin
                if (i != 4) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
            v_reg[4] <= v_reg[3] + t1;
            v_reg[0] <= t1 + t2;
        end
        if (put_en && pos_reg == 6'd63) begin
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= h_reg[i];
            end
        end
        if (!aresetn) begin
            state_reg     <= StIdle;
            ret_reg       <= StIdle;
            bit_count_reg <= '0;
            pos_reg       <= '0;
            round_reg     <= '0;
            len_reg       <= '0;
            fin_reg       <= 1'b0;
            out_idx_reg   <= '0;
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= sha256_pkg::InitialH[i];
            end
        end else begin
            if (put_en) begin
                pos_reg <= pos_reg + 6'd1;
            end
            case (state_reg)
                StIdle: begin
                    if (q_valid) begin
                        if (q_cmd.byte_present) begin
                            bit_count_reg <= bit_count_reg + 64'd8;
                        end
                        fin_reg <= 1'b0;
                        len_reg <= '0;
                        ret_reg <= q_cmd.end_of_message ? StPad : StIdle;
                        if (put_en && pos_reg == 6'd63) begin
                            state_reg <= StRound;
                            round_reg <= '0;
                        end else if (q_cmd.end_of_message) begin
                            state_reg <= StPad;
                        end
                    end
                end
                StPad: begin
                    fin_reg <= 1'b1;
                    ret_reg <= StPad;
                    if (pos_reg == 6'd55) begin
                        state_reg <= StLen;
                    end else if (pos_reg == 6'd63) begin
                        state_reg <= StRound;
                        round_reg <= '0;
                    end
                end
                StLen: begin
                    len_reg <= len_reg + 3'd1;
                    if (len_reg == 3'd7) begin
                        ret_reg   <= StOut;
                        state_reg <= StRound;
                        round_reg <= '0;
                    end
                end
                StRound: begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63) begin
                        state_reg <= StAdd;
                    end
                end
                StAdd: begin
                    for (int i = 0; i < 8; i++) begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    out_idx_reg <= '0;
                    state_reg   <= ret_reg;
                end
                StOut: begin
                    if (m_ready) begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7) begin
                            state_reg     <= StIdle;
                            bit_count_reg <= '0;
                            pos_reg       <= '0;
                            for (int i = 0; i < 8; i++) begin
                                h_reg[i] <= sha256_pkg::InitialH[i];
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= StIdle;
                end
            endcase
        end
    end
endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the SHA-256 message hasher with a digest scoreboard.
`timescale 1ns / 1ps
module tb_top;

    class digest_scoreboard;
        logic [31:0] chain [8];
        logic [31:0] words [16];
        logic [63:0] msg_bits;
        int unsigned fill;
        logic [31:0] pending_word [$];
        logic [2:0]  pending_index [$];
        logic        pending_last [$];
        int unsigned errors;
        int unsigned digests;

        function new();
            errors = 0;
            digests = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) chain[i] = sha256_pkg::InitialH[i];
            msg_bits = '0;
            fill = 0;
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] t1, t2;
            for (int i = 0; i < 16; i++) w[i] = words[i];
            for (int i = 16; i < 64; i++)
                w[i] = w[i-16] + w[i-7]
                     + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                     + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
            for (int i = 0; i < 8; i++) v[i] = chain[i];
            for (int i = 0; i < 64; i++) begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[i] + w[i];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] += v[i];
        endfunction

        function void absorb(logic [7:0] b);
            if (fill % 4 == 0) words[fill / 4] = '0;
            words[fill / 4][(3 - fill % 4) * 8 +: 8] = b;
            fill = (fill + 1) % 64;
            if (fill == 0) compress();
        endfunction

        function void note_beat(logic [7:0] b, logic present, logic eom);
            logic [63:0] len;
            if (present) begin
                absorb(b);
                msg_bits += 64'd8;
            end
            if (!eom) return;
            len = msg_bits;
            absorb(8'h80);
            while (fill != 56) absorb(8'h00);
            for (int s = 56; s >= 0; s -= 8) absorb(len[s +: 8]);
            for (int i = 0; i < 8; i++) begin
                pending_word  = {pending_word, chain[i]};
                pending_index = {pending_index, i[2:0]};
                pending_last  = {pending_last, (i == 7)};
            end
            restart();
        endfunction

        function void check_word(logic [31:0] d, logic [2:0] idx, logic lst);
            logic [31:0] ew;
            logic [2:0]  ei;
            logic        el;
            if (pending_word.size() == 0) begin
                $display("%0t: unexpected digest beat %h", $time, d);
                errors++;
                return;
            end
            ew = pending_word.pop_front();
            ei = pending_index.pop_front();
            el = pending_last.pop_front();
            if (d !== ew) begin
                $display("%0t: digest_word expected %h actual %h", $time, ew, d);
                errors++;
            end
            if (idx !== ei) begin
                $display("%0t: word_index expected %0d actual %0d", $time, ei, idx);
                errors++;
            end
            if (lst !== el) begin
                $display("%0t: last_word expected %0b actual %0b", $time, el, lst);
                errors++;
            end
            if (lst === 1'b1) digests++;
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_byte_present = 1'b0;
    logic        s_end_of_message = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last_word;

    digest_scoreboard board = new();
    bit quiet = 1'b0;
    int unsigned beats_sent = 0;

    always #6 aclk = ~aclk;

    sha256_message_hasher DUT (.*);

    task automatic send_beat(logic [7:0] b, logic present, logic eom);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_byte_present <= present;
        s_end_of_message <= eom;
        do @(posedge aclk); while (!s_ready);
        board.note_beat(b, present, eom);
        beats_sent++;
    endtask

    task automatic send_message(int n);
        for (int i = 0; i < n; i++)
            send_beat(8'($urandom_range(0, 255)), 1'b1, (i == n - 1));
        if (n == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_word(m_digest_word, m_word_index, m_last_word);
    end

    initial begin
        int unsigned burst;
        burst = 0;
        forever begin
            @(posedge aclk);
            if (quiet) m_ready <= 1'b1;
            else if (burst > 0) begin
                burst--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                burst = $urandom_range(0, 18);
                m_ready <= 1'b0;
            end else m_ready <= 1'b1;
        end
    end

    initial begin
        int guard;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Directed: empty message, one byte with end, idle beats, block edges.
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hff, 1'b1, 1'b1);
        send_beat(8'h5a, 1'b0, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'ha5, 1'b0, 1'b0);
        send_beat(8'h80, 1'b1, 1'b0);
        send_beat(8'h01, 1'b0, 1'b1);
        send_message(56);
        send_message(64);
        // Short random messages with idle beats mixed in, random stalls at first.
        while (beats_sent < 130) begin
            if (beats_sent > 120) quiet = 1'b1;
            if ($urandom_range(0, 9) == 0)
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            else
                send_message(int'($urandom_range(0, 6)));
        end
        s_valid <= 1'b0;
        guard = 0;
        while (board.pending_word.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (200) @(posedge aclk);
        $display("Covered %0d input beats and %0d digests, including empty messages,",
                 beats_sent, board.digests);
        $display("padding across block boundaries and idle beats without a byte.");
        if (board.errors == 0 && board.pending_word.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end
endmodule
